// ===== hdl/wmra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmra_pkg: shared constants for the warm-up mean / running average block
// Widths of the sample, accumulator, window register and the divide datapath.
// ----------------------------------------------------------------------------
package wmra_pkg;

    localparam int SAMPLE_WIDTH = 16;
    // stream data bus, padded to whole bytes
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ACC_W        = 24;
    localparam int WIN_W        = 8;
    localparam int CNT_W        = WIN_W + 1;
    localparam int PROD_W       = ACC_W + WIN_W;
    // product plus one sample; SAMPLE_WIDTH never exceeds PROD_W
    localparam int DVD_W        = PROD_W + 1;
    localparam int DIV_CNT_W    = $clog2(DVD_W + 1);

endpackage : wmra_pkg
`default_nettype wire

// ===== hdl/wmra_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmra_div: iterative restoring divider
// One quotient bit per cycle; divisor must stay stable while busy.
// ----------------------------------------------------------------------------
module wmra_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wmra_pkg::DVD_W-1:0]   dividend,
    input  wire logic [wmra_pkg::WIN_W-1:0]   divisor,
    output logic                              done,
    output logic [wmra_pkg::DVD_W-1:0]        quotient
);

    logic [wmra_pkg::DVD_W-1:0]     work_reg, work_next;
    logic [wmra_pkg::WIN_W-1:0]     rem_reg, rem_next;
    logic [wmra_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;

    logic [wmra_pkg::WIN_W:0] trial;
    logic [wmra_pkg::WIN_W:0] diff;
    logic                     ge;

    assign trial = {rem_reg, work_reg[wmra_pkg::DVD_W-1]};
    assign ge    = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = wmra_pkg::DIV_CNT_W'(wmra_pkg::DVD_W);
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so it fits WIN_W bits
            rem_next  = ge ? diff[wmra_pkg::WIN_W-1:0] : trial[wmra_pkg::WIN_W-1:0];
            work_next = {work_reg[wmra_pkg::DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == wmra_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule : wmra_div
`default_nettype wire

// ===== hdl/warmup_mean_then_running_average.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// warmup_mean_then_running_average: block mean, then 1/N running average
// Sequencer around one multiplier and a shared iterative divider.
// ----------------------------------------------------------------------------
// One sample per input beat, one result beat per sample. The first N samples
// (N = window_count, 0 read as 1) are summed and answered with average 0,
// settled 0; the beat after them answers sum / N (its sample is dropped);
// every later beat answers (avg * (N-1) + sample) / N, truncated, settled 1.
// A warm-up beat goes from acceptance to the output register without the
// divider. The mean beat passes the 33-step restoring divider (one quotient
// bit a cycle); a running-average beat passes a registered multiply and add
// before it. s_axis_tready is high only while the sequencer is idle;
// the output register lets the next beat be taken while a result waits.
// window_count may only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module warmup_mean_then_running_average (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [wmra_pkg::WIN_W-1:0]    cfg_wr_data,   // window_count
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [wmra_pkg::TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [wmra_pkg::TDATA_W-1:0]       m_axis_tdata,  // [15:0] average
    output logic [0:0]                         m_axis_tuser   // [0] settled
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [wmra_pkg::WIN_W-1:0]          win_reg, win_next;
    logic [wmra_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [wmra_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [wmra_pkg::WIN_W-1:0]          n_reg, n_next;
    logic [wmra_pkg::SAMPLE_WIDTH-1:0]   sample_reg, sample_next;
    logic [wmra_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [wmra_pkg::DVD_W-1:0]          dvd_reg, dvd_next;
    logic                                settled_reg, settled_next;
    logic                                out_valid_reg, out_valid_next;
    logic [wmra_pkg::SAMPLE_WIDTH-1:0]   out_avg_reg, out_avg_next;
    logic                                out_settled_reg, out_settled_next;

    logic                                in_fire;
    logic                                out_load;
    logic [wmra_pkg::WIN_W-1:0]          n_eff;
    logic [wmra_pkg::CNT_W-1:0]          n_ext;
    logic [wmra_pkg::SAMPLE_WIDTH-1:0]   s_sample;
    logic                                div_start;
    logic                                div_done;
    logic [wmra_pkg::DVD_W-1:0]          div_q;

    assign s_sample  = s_axis_tdata[wmra_pkg::SAMPLE_WIDTH-1:0];
    assign n_eff     = (win_reg == '0) ? wmra_pkg::WIN_W'(1) : win_reg;
    assign n_ext     = {1'b0, n_eff};
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign div_start = (state_reg == ST_START);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    wmra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next       = state_reg;
        win_next         = cfg_wr_en ? cfg_wr_data : win_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        n_next           = n_reg;
        sample_next      = sample_reg;
        prod_next        = prod_reg;
        dvd_next         = dvd_reg;
        settled_next     = settled_reg;
        out_avg_next     = out_avg_reg;
        out_settled_next = out_settled_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    n_next      = n_eff;
                    sample_next = s_sample;
                    if (count_reg > n_ext) begin
                        // settled: running-average step
                        state_next = ST_MUL;
                    end else if (count_reg == n_ext) begin
                        // end of warm-up: mean of the sum, sample dropped
                        dvd_next   = wmra_pkg::DVD_W'(acc_reg);
                        count_next = count_reg + 1'b1;
                        state_next = ST_START;
                    end else begin
                        acc_next     = acc_reg + wmra_pkg::ACC_W'(s_sample);
                        count_next   = count_reg + 1'b1;
                        settled_next = 1'b0;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = wmra_pkg::PROD_W'(acc_reg) * wmra_pkg::PROD_W'(n_reg - 1'b1);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                dvd_next   = wmra_pkg::DVD_W'(prod_reg) + wmra_pkg::DVD_W'(sample_reg);
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    acc_next     = div_q[wmra_pkg::ACC_W-1:0];
                    settled_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    out_valid_next   = 1'b1;
                    out_settled_next = settled_reg;
                    out_avg_next     = settled_reg ? acc_reg[wmra_pkg::SAMPLE_WIDTH-1:0] : '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            win_reg       <= wmra_pkg::WIN_W'(8);
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg           <= n_next;
        sample_reg      <= sample_next;
        prod_reg        <= prod_next;
        dvd_reg         <= dvd_next;
        settled_reg     <= settled_next;
        out_avg_reg     <= out_avg_next;
        out_settled_reg <= out_settled_next;
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = wmra_pkg::TDATA_W'(out_avg_reg);
    assign m_axis_tuser[0] = out_settled_reg;

endmodule : warmup_mean_then_running_average
`default_nettype wire
